// ===== design/box_depth_grid_average_defines.svh =====
// assertion macros shared by the box depth grid average design
// no dependencies; included by the modules that carry assertions
`ifndef BOX_DEPTH_GRID_AVERAGE_DEFINES_SVH
`define BOX_DEPTH_GRID_AVERAGE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BDGA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BDGA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/bdga_pkg.sv =====
// shared types, widths and the helper function of the box depth grid average design
// no dependencies
package bdga_pkg;

	localparam int DEF_FRAME_W = 320;
	localparam int DEF_FRAME_H = 240;

	localparam int PIX_X_W  = 9;
	localparam int PIX_Y_W  = 8;
	localparam int COORD_W  = 10;
	localparam int DEPTH_W  = 16;
	localparam int COUNT_W  = 7;
	localparam int STEP_W   = 7;
	localparam int SUM_W    = 22;

	// grid points per axis and the walk index over all of them
	localparam int GRID_N     = 8;
	localparam int GRID_ROW_W = $clog2(GRID_N);
	localparam int GRID_IDX_W = $clog2(GRID_N * GRID_N);

	// divide by nine as multiply by reciprocal, exact for 10-bit operands
	localparam int DIV9_MUL_W = 12;
	localparam int DIV9_MUL   = 3641;
	localparam int DIV9_SHIFT = 15;

	localparam int QUEUE_DEPTH = 4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic               opcode;
		logic [PIX_X_W-1:0] pix_x;
		logic [PIX_Y_W-1:0] pix_y;
		logic [DEPTH_W-1:0] pix_depth;
		logic [COORD_W-1:0] left_x;
		logic [COORD_W-1:0] top_y;
		logic [COORD_W-1:0] right_x;
		logic [COORD_W-1:0] bottom_y;
	} in_t;

	typedef struct packed {
		logic [DEPTH_W-1:0] mean_depth;
		logic [COUNT_W-1:0] sample_count;
		logic               no_samples;
		logic               bad_box;
	} out_t;

	// classified command between front and back
	typedef struct packed {
		logic               is_query;
		logic               wr_ok;
		logic               bad;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [DEPTH_W-1:0] depth;
		logic [STEP_W-1:0]  sx;
		logic [STEP_W-1:0]  sy;
	} cmd_t;

	function automatic logic [STEP_W-1:0] div9(input logic [COORD_W-1:0] d);
		logic [COORD_W+DIV9_MUL_W-1:0] p;
		p = (COORD_W+DIV9_MUL_W)'(d) * (COORD_W+DIV9_MUL_W)'(DIV9_MUL);
		return p[DIV9_SHIFT +: STEP_W];
	endfunction

endpackage

// ===== design/bdga_fifo.sv =====
// short command queue between the front and back parts
// depends on bdga_pkg
module bdga_fifo import bdga_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  cmd_t wdata,
	output logic full,
	input  logic rd,
	output cmd_t rdata,
	output logic empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t             slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slots_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/bdga_front.sv =====
// front part: accepts words, clamps boxes, derives grid steps, classifies writes
// depends on bdga_pkg
module bdga_front import bdga_pkg::*; #(
	parameter int FRAME_W = DEF_FRAME_W,
	parameter int FRAME_H = DEF_FRAME_H
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  in_t  item,
	output logic q_wr,
	output cmd_t q_cmd,
	input  logic q_full
);

	logic               v_s1;
	in_t                item_s1;
	logic [COORD_W-1:0] x2c;
	logic [COORD_W-1:0] y2c;
	logic [COORD_W-1:0] dx;
	logic [COORD_W-1:0] dy;
	logic               accept;

	assign full   = v_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = v_s1;

	always_comb begin
		x2c = ({1'b0, item_s1.right_x} >= (COORD_W+1)'(FRAME_W)) ?
			COORD_W'(FRAME_W - 1) : item_s1.right_x;
		y2c = ({1'b0, item_s1.bottom_y} >= (COORD_W+1)'(FRAME_H)) ?
			COORD_W'(FRAME_H - 1) : item_s1.bottom_y;
		dx = x2c - item_s1.left_x;
		dy = y2c - item_s1.top_y;

		q_cmd.is_query = (item_s1.opcode == OP_QUERY);
		q_cmd.wr_ok    = (item_s1.opcode == OP_WRITE) &&
			((COORD_W+1)'(item_s1.pix_x) < (COORD_W+1)'(FRAME_W)) &&
			((COORD_W+1)'(item_s1.pix_y) < (COORD_W+1)'(FRAME_H));
		q_cmd.bad      = (x2c < item_s1.left_x) || (y2c < item_s1.top_y);
		q_cmd.x        = q_cmd.is_query ? item_s1.left_x : COORD_W'(item_s1.pix_x);
		q_cmd.y        = q_cmd.is_query ? item_s1.top_y : COORD_W'(item_s1.pix_y);
		q_cmd.depth    = item_s1.pix_depth;
		q_cmd.sx       = div9(dx);
		q_cmd.sy       = div9(dy);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (!q_full) begin
			v_s1 <= 1'b0;
		end
	end

endmodule

// ===== design/bdga_div.sv =====
// restoring divider for the sample mean, one quotient bit per cycle
// depends on bdga_pkg
module bdga_div import bdga_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SUM_W-1:0]   dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [DEPTH_W-1:0] quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   steps_q;
	logic [COUNT_W-1:0] rem_q;
	logic [COUNT_W-1:0] dsr_q;
	logic [SUM_W-1:0]   quo_q;
	logic [COUNT_W:0]   rem_sh;
	logic               fits;

	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign fits     = (rem_sh >= {1'b0, dsr_q});
	assign done     = done_q;
	assign quotient = quo_q[DEPTH_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? COUNT_W'(rem_sh - {1'b0, dsr_q}) : COUNT_W'(rem_sh);
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				steps_q <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				steps_q <= steps_q - 1'b1;
				if (steps_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== design/bdga_back.sv =====
// back part: depth image store, grid walk, accumulation and result register
// depends on bdga_pkg, bdga_div and box_depth_grid_average_defines.svh
`include "box_depth_grid_average_defines.svh"

module bdga_back import bdga_pkg::*; #(
	parameter int FRAME_W = DEF_FRAME_W,
	parameter int FRAME_H = DEF_FRAME_H
) (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t q_cmd,
	input  logic q_empty,
	output logic q_rd,
	output logic empty,
	input  logic pop,
	output out_t result
);

	localparam int STORE_DEPTH = FRAME_W * FRAME_H;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DIV   = 2'd3;

	logic [DEPTH_W-1:0]    depth_store [STORE_DEPTH];

	logic [1:0]            state_q;
	logic [GRID_IDX_W-1:0] idx_q;
	logic [COORD_W-1:0]    px_q;
	logic [COORD_W-1:0]    py_q;
	logic [COORD_W-1:0]    ystart_q;
	logic [STEP_W-1:0]     sx_q;
	logic [STEP_W-1:0]     sy_q;
	logic [SUM_W-1:0]      sum_q;
	logic [COUNT_W-1:0]    cnt_q;

	logic                  wr_s1;
	logic                  rd_s1;
	logic [ADDR_W-1:0]     addr_s1;
	logic [DEPTH_W-1:0]    wdata_s1;
	logic                  rd_s2;
	logic [DEPTH_W-1:0]    rdata_s2;

	logic                  res_valid_q;
	out_t                  res_q;

	logic                  head_ok;
	logic                  start_query;
	logic                  wr_issue;
	logic                  rd_issue;
	logic [COORD_W-1:0]    iss_x;
	logic [COORD_W-1:0]    iss_y;
	logic [ADDR_W-1:0]     iss_addr;
	logic                  drained;
	logic                  div_start;
	logic                  div_done;
	logic [DEPTH_W-1:0]    div_quo;
	logic                  res_load;
	out_t                  res_next;

	// a query waits for the result register; writes flow past it
	assign head_ok     = !q_empty && (!q_cmd.is_query || !res_valid_q);
	assign q_rd        = (state_q == ST_IDLE) && head_ok;
	assign start_query = q_rd && q_cmd.is_query && !q_cmd.bad;
	assign wr_issue    = q_rd && !q_cmd.is_query && q_cmd.wr_ok;
	assign rd_issue    = (state_q == ST_WALK);
	assign iss_x       = rd_issue ? px_q : q_cmd.x;
	assign iss_y       = rd_issue ? py_q : q_cmd.y;
	assign iss_addr    = ADDR_W'(iss_y) * ADDR_W'(FRAME_W) + ADDR_W'(iss_x);
	assign drained     = (state_q == ST_DRAIN) && !rd_s1 && !rd_s2;
	assign div_start   = drained && (cnt_q != '0);

	assign empty  = !res_valid_q;
	assign result = res_q;

	always_comb begin
		res_load = 1'b0;
		res_next = '0;
		if (q_rd && q_cmd.is_query && q_cmd.bad) begin
			res_load         = 1'b1;
			res_next.bad_box = 1'b1;
		end else if (drained && (cnt_q == '0)) begin
			res_load            = 1'b1;
			res_next.no_samples = 1'b1;
		end else if ((state_q == ST_DIV) && div_done) begin
			res_load              = 1'b1;
			res_next.mean_depth   = div_quo;
			res_next.sample_count = cnt_q;
		end
	end

	bdga_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// store access stage
	always_ff @(posedge clk) begin
		if (wr_s1) begin
			depth_store[addr_s1] <= wdata_s1;
		end
		if (rd_s1) begin
			rdata_s2 <= depth_store[addr_s1];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		addr_s1  <= iss_addr;
		wdata_s1 <= q_cmd.depth;
		if (res_load) begin
			res_q <= res_next;
		end
		if (start_query) begin
			px_q     <= q_cmd.x + COORD_W'(q_cmd.sx);
			py_q     <= q_cmd.y + COORD_W'(q_cmd.sy);
			ystart_q <= q_cmd.y + COORD_W'(q_cmd.sy);
			sx_q     <= q_cmd.sx;
			sy_q     <= q_cmd.sy;
			sum_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (rd_issue) begin
				// rows inner, columns outer
				if (idx_q[GRID_ROW_W-1:0] == '1) begin
					py_q <= ystart_q;
					px_q <= px_q + COORD_W'(sx_q);
				end else begin
					py_q <= py_q + COORD_W'(sy_q);
				end
			end
			if (rd_s2 && (rdata_s2 != '0)) begin
				sum_q <= sum_q + SUM_W'(rdata_s2);
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			wr_s1       <= 1'b0;
			rd_s1       <= 1'b0;
			rd_s2       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			wr_s1 <= wr_issue;
			rd_s1 <= rd_issue;
			rd_s2 <= rd_s1;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (start_query) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == '1) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drained) begin
						state_q <= (cnt_q == '0) ? ST_IDLE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`BDGA_ASSERT_IMP(a_res_no_overwrite, clk, arst_n, res_load, !res_valid_q, "result overwritten")
	`BDGA_ASSERT_IMP(a_div_after_drain, clk, arst_n, state_q == ST_DIV, !rd_s1 && !rd_s2 && !wr_s1, "divide with store access in flight")
	`BDGA_ASSERT_IMP(a_div_nonzero, clk, arst_n, div_start, cnt_q != '0, "divide by zero count")
	`BDGA_ASSERT_IMP(a_reads_in_query, clk, arst_n, rd_s2, state_q == ST_WALK || state_q == ST_DRAIN, "store read outside a query")

endmodule

// ===== design/box_depth_grid_average.sv =====
// top level of the box depth grid average block
// depends on bdga_pkg, bdga_front, bdga_fifo and bdga_back
//
// Keeps a FRAME_W x FRAME_H image of 16-bit depths and answers box
// queries with the mean of the nonzero depths on the 8x8 interior grid of
// the box. A write word (opcode 0) stores pix_depth at (pix_x, pix_y) and
// gives no result; writes outside the image are dropped. A query word
// (opcode 1) clamps right_x/bottom_y to the image, steps the box in ninths
// and returns one result word: mean_depth and sample_count, or
// no_samples when every grid depth was zero, or bad_box when the clamped
// box is reversed or starts outside the image. Writes sustain one word per
// clock while no query occupies or waits for the back end. A query holds
// the back end while it is taken from the queue, makes 64 store reads (one
// read port, one grid point a cycle), drains the read pipeline and starts
// the divider, runs the 22 steps of the bit-serial mean divider and loads
// the result; the result word shows on the next cycle. An empty grid loads
// its result at the end of the drain and a bad box in the cycle it leaves the queue.
// Words queue in front of the back end (QUEUE_DEPTH entries plus one input
// stage), and a finished result waits in its own register, so writes keep
// flowing while a result is held. Grid points that read pixels never
// written give undefined depths. There is no clearing pass after reset.
module box_depth_grid_average import bdga_pkg::*; #(
	parameter int FRAME_W = DEF_FRAME_W,
	parameter int FRAME_H = DEF_FRAME_H
) (
	input  logic clk,
	input  logic arst_n,
	// input words
	input  logic push,
	output logic full,
	input  in_t  item,
	// result words
	output logic empty,
	input  logic pop,
	output out_t result
);

	// classified commands between the two halves
	logic q_wr;
	logic q_full;
	cmd_t q_wdata;
	logic q_rd;
	logic q_empty;
	cmd_t q_rdata;

	bdga_front #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_wr   (q_wr),
		.q_cmd  (q_wdata),
		.q_full (q_full)
	);

	bdga_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	// store, grid walk, divider and result register
	bdga_back #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_cmd   (q_rdata),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
